/* hdl/gforce_gravity_removal_peak_tracker_core_macros.svh */
// assertion macros for the checker file
`ifndef GFORCE_GRAVITY_REMOVAL_PEAK_TRACKER_CORE_MACROS_SVH
`define GFORCE_GRAVITY_REMOVAL_PEAK_TRACKER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define GFGR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define GFGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gfgr_pkg.sv */
package gfgr_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_CAL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TRK_MUL,
    ST_TRK_ACC,
    ST_LIN_MUL,
    ST_LIN_ACC,
    ST_SM_MUL,
    ST_SM_ACC,
    ST_OUT
  } state_t;

  // input operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_RESET_PEAKS = 2'd1,
    OP_START_CAL   = 2'd2
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_FACTOR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR_STILL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_LEVEL         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_MARGIN         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_WINDOW_MS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LIMIT       = 3'd6;

  // field and state widths
  localparam int OP_W      = 2;
  localparam int TIME_W    = 32;
  localparam int FACTOR_W  = 16;
  localparam int STILL_W   = 13;
  localparam int MARGIN_W  = 12;
  localparam int WINDOW_W  = 16;
  localparam int LIMIT_W   = 14;
  localparam int GRAV_W    = 32;
  localparam int SMOOTH_W  = 24;
  localparam int PEAK_W    = 15;
  localparam int DISP_W    = 15;
  localparam int SUM_W     = 32;
  localparam int COUNT_W   = 16;
  localparam int OUT_TDATA_W = 96;

  // fixed point
  localparam int GRAV_FRAC   = 8;
  localparam int SMOOTH_FRAC = 4;
  localparam int G_SCALE     = 26731;  // Q16 of 4/9.80665
  localparam logic [PEAK_W-1:0]  PEAK_MAX  = 15'h7fff;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

  // shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // g values after scaling
  localparam int GV_W = 28;
  localparam int GQ_W = 32;

  // shared divider
  localparam int DIV_N_W   = 40;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/gforce_gravity_removal_peak_tracker_core.sv */
// g-force meter core. each accepted transaction carries an op in s_axis_tuser
// (sample, reset peaks, start calibration) and three accelerometer axes plus a
// millisecond timestamp in s_axis_tdata; each one returns exactly one result
// transaction with the calibrating flag in m_axis_tuser and the two clamped
// display values and four held peaks in m_axis_tdata. after reset, and after a
// start-calibration op, samples are summed until calib_window_ms has passed;
// the closing sample sets gravity to the rounded mean and then runs the normal
// path. the normal path tracks gravity with a slow q16 average, removes it from
// the lateral and longitudinal axes, scales to 1/4096 g, smooths (faster below
// still_level) and updates the peaks, which need peak_margin to be beaten.
// all products go through one registered 34x18 multiplier and the calibration
// mean through one bit-serial 40-bit divider, so one item is in flight at a
// time: a peak-reset, start-calibration or unused op only passes through the
// event state, a sample with the window still open is only summed, a tracking
// sample runs seven multiplies, and the sample that closes calibration first
// runs three 40-step divisions in a row. the output register lets the next
// item be accepted while a result waits. configuration writes are always
// taken and must only happen while idle.
module gforce_gravity_removal_peak_tracker_core import gfgr_pkg::*; #(
  parameter int  ACCEL_BITS = 16,
  localparam int IN_TDATA_W = ((3 * ACCEL_BITS + TIME_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_lat, accel_long, accel_vert, time_ms, zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic [OP_W-1:0]       s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // display_lat, display_long, peak_forward, peak_brake, peak_left,
  // peak_right, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // calibrating
  output logic [0:0]            m_axis_tuser
);

  localparam logic [1:0] LAST_AXIS   = 2'd2;
  localparam logic [1:0] LAST_LINEAR = 2'd1;
  localparam int DISP_SH_W = SMOOTH_W - SMOOTH_FRAC + 1;
  localparam int OUT_PAD_W = OUT_TDATA_W - 2 * DISP_W - 4 * PEAK_W;

  localparam logic signed [PROD_W-1:0]  RND16 = PROD_W'(1) <<< 15;
  localparam logic signed [PROD_W-1:0]  RND20 = PROD_W'(1) <<< 19;
  localparam logic signed [PROD_W-1:0]  RND24 = PROD_W'(1) <<< 23;
  localparam logic signed [MUL_A_W-1:0] SM_HI = MUL_A_W'(2**(SMOOTH_W-1) - 1);
  localparam logic signed [MUL_A_W-1:0] SM_LO = ~SM_HI;
  localparam logic signed [SMOOTH_W:0]  DISP_RND = (SMOOTH_W+1)'(1) <<< (SMOOTH_FRAC-1);
  localparam logic signed [GV_W-1:0]    PEAK_MAX_S = GV_W'(PEAK_MAX);

  // configuration registers
  logic [FACTOR_W-1:0] gravity_factor;
  logic [FACTOR_W-1:0] smooth_factor;
  logic [FACTOR_W-1:0] smooth_factor_still;
  logic [STILL_W-1:0]  still_level;
  logic [MARGIN_W-1:0] peak_margin;
  logic [WINDOW_W-1:0] calib_window_ms;
  logic [LIMIT_W-1:0]  display_limit;

  // tracker state
  logic signed [GRAV_W-1:0]   grav [3];
  logic signed [SMOOTH_W-1:0] smooth [2];
  logic [PEAK_W-1:0]          peak [4];  // forward, brake, left, right
  logic                       in_cal;
  logic [TIME_W-1:0]          cal_start;
  logic signed [SUM_W-1:0]    cal_sum [3];
  logic [COUNT_W-1:0]         cal_count;

  // latched transaction
  logic [OP_W-1:0]              op_r;
  logic signed [ACCEL_BITS-1:0] acc_r [3];
  logic [TIME_W-1:0]            time_r;

  // sequencer
  state_t     state;
  state_t     state_next;
  logic [1:0] ax;
  logic [1:0] ax_next;
  logic       mul_en;
  logic       div_start;
  logic       ld_out;
  logic       in_fire;

  // per-lane temporaries between multiplier passes
  logic signed [GQ_W-1:0] gq_r;
  logic [FACTOR_W-1:0]    f_r;

  // output register
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   out_cal;

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [DIV_N_W-1:0]        div_num;
  logic [DIV_N_W-1:0]        div_q;
  div_stat_t                 div_stat;

  // datapath
  logic signed [MUL_A_W-1:0] a_sc;
  logic signed [MUL_A_W-1:0] diff_ag;
  logic signed [MUL_A_W-1:0] sm_diff;
  logic signed [PROD_W-1:0]  sum16, sum20, sum24;
  logic signed [PROD_W-1:0]  shr16, shr20, shr24;
  logic signed [GRAV_W-1:0]  grav_trk;
  logic signed [GQ_W-1:0]    gq;
  logic signed [GV_W-1:0]    gv;
  logic signed [GV_W-1:0]    gv_neg;
  logic [GV_W-1:0]           gv_mag;
  logic                      is_still;
  logic signed [MUL_A_W-1:0] sm_sum;
  logic signed [SMOOTH_W-1:0] sm_new;
  logic [SUM_W:0]            sum_ext [3];
  logic signed [SUM_W-1:0]   sum_sat [3];
  logic [TIME_W-1:0]         elapsed;
  logic                      win_open;
  logic [SUM_W-1:0]          sum_mag;
  logic signed [GRAV_W-1:0]  cal_q;
  logic signed [GRAV_W-1:0]  cal_mean;
  logic signed [SMOOTH_W:0]  disp_ext [2];
  logic signed [DISP_SH_W-1:0] disp_sh [2];
  logic signed [DISP_SH_W-1:0] disp_lim;
  logic signed [DISP_SH_W-1:0] disp_val [2];

  function automatic logic [PEAK_W-1:0] peak_upd(
    input logic [PEAK_W-1:0]      pk,
    input logic signed [GV_W-1:0] v,
    input logic [MARGIN_W-1:0]    margin
  );
    logic signed [GV_W-1:0] thr;
    logic [PEAK_W-1:0]      res;
    thr = $signed(GV_W'(pk)) + $signed(GV_W'(margin));
    res = pk;
    if (v > thr) begin
      res = (v > PEAK_MAX_S) ? PEAK_MAX : v[PEAK_W-1:0];
    end
    return res;
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ax    <= '0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
    end
  end

  always_comb begin
    state_next = state;
    ax_next    = ax;
    mul_en     = 1'b0;
    div_start  = 1'b0;
    ld_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        ax_next = '0;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OP_SAMPLE) begin
            state_next = in_cal ? ST_CAL : ST_TRK_MUL;
          end else begin
            state_next = ST_EVENT;
          end
        end
      end
      ST_EVENT: begin
        state_next = ST_OUT;
      end
      ST_CAL: begin
        // window still open: sample only summed
        state_next = win_open ? ST_OUT : ST_DIV_GO;
        ax_next    = '0;
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (ax == LAST_AXIS) begin
            ax_next    = '0;
            state_next = ST_TRK_MUL;
          end else begin
            ax_next    = ax + 1'b1;
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_TRK_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_TRK_ACC;
      end
      ST_TRK_ACC: begin
        if (ax == LAST_AXIS) begin
          ax_next    = '0;
          state_next = ST_LIN_MUL;
        end else begin
          ax_next    = ax + 1'b1;
          state_next = ST_TRK_MUL;
        end
      end
      ST_LIN_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_LIN_ACC;
      end
      ST_LIN_ACC: begin
        state_next = ST_SM_MUL;
      end
      ST_SM_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_SM_ACC;
      end
      ST_SM_ACC: begin
        if (ax == LAST_LINEAR) begin
          ax_next    = '0;
          state_next = ST_OUT;
        end else begin
          ax_next    = ax + 1'b1;
          state_next = ST_LIN_MUL;
        end
      end
      ST_OUT: begin
        // wait only while the previous result is still held
        if (!out_valid || m_axis_tready) begin
          ld_out     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- shared units
  gfgr_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  gfgr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cal_count),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    a_sc    = MUL_A_W'(acc_r[ax]) <<< GRAV_FRAC;
    diff_ag = a_sc - MUL_A_W'(grav[ax]);
    sm_diff = MUL_A_W'(gq_r) - MUL_A_W'(smooth[ax[0]]);

    case (state)
      ST_TRK_MUL: begin
        mul_a = diff_ag;
        mul_b = MUL_B_W'(gravity_factor);
      end
      ST_LIN_MUL: begin
        mul_a = diff_ag;
        mul_b = MUL_B_W'(G_SCALE);
      end
      ST_SM_MUL: begin
        mul_a = sm_diff;
        mul_b = MUL_B_W'(f_r);
      end
      default: begin
        mul_a = diff_ag;
        mul_b = '0;
      end
    endcase

    // round half up on the registered product
    sum16 = prod + RND16;
    sum20 = prod + RND20;
    sum24 = prod + RND24;
    shr16 = sum16 >>> 16;
    shr20 = sum20 >>> 20;
    shr24 = sum24 >>> 24;

    grav_trk = grav[ax] + shr16[GRAV_W-1:0];

    // g at 1/65536 and 1/4096 from one product
    gq       = shr20[GQ_W-1:0];
    gv       = shr24[GV_W-1:0];
    gv_neg   = -gv;
    gv_mag   = gv[GV_W-1] ? gv_neg : gv;
    is_still = gv_mag < GV_W'(still_level);

    sm_sum = MUL_A_W'(smooth[ax[0]]) + shr16[MUL_A_W-1:0];
    if (sm_sum > SM_HI) begin
      sm_new = SM_HI[SMOOTH_W-1:0];
    end else if (sm_sum < SM_LO) begin
      sm_new = SM_LO[SMOOTH_W-1:0];
    end else begin
      sm_new = sm_sum[SMOOTH_W-1:0];
    end

    // saturating calibration sums, one adder per axis
    for (int i = 0; i < 3; i++) begin
      sum_ext[i] = {cal_sum[i][SUM_W-1], cal_sum[i]} + (SUM_W+1)'(acc_r[i]);
      if (sum_ext[i][SUM_W] != sum_ext[i][SUM_W-1]) begin
        sum_sat[i] = sum_ext[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_sat[i] = sum_ext[i][SUM_W-1:0];
      end
    end

    elapsed  = time_r - cal_start;
    win_open = elapsed < TIME_W'(calib_window_ms);

    // mean rounds to nearest, ties away from zero, on the magnitude
    sum_mag  = cal_sum[ax][SUM_W-1] ? -cal_sum[ax] : cal_sum[ax];
    div_num  = {sum_mag, {GRAV_FRAC{1'b0}}} + DIV_N_W'(cal_count >> 1);
    cal_q    = div_q[GRAV_W-1:0];
    if (cal_count == '0) begin
      cal_mean = '0;
    end else begin
      cal_mean = cal_sum[ax][SUM_W-1] ? -cal_q : cal_q;
    end

    // display values, zero while calibrating
    disp_lim = DISP_SH_W'(display_limit);
    for (int i = 0; i < 2; i++) begin
      disp_ext[i] = (SMOOTH_W+1)'(smooth[i]) + DISP_RND;
      disp_sh[i]  = DISP_SH_W'(disp_ext[i] >>> SMOOTH_FRAC);
      if (in_cal) begin
        disp_val[i] = '0;
      end else if (disp_sh[i] > disp_lim) begin
        disp_val[i] = disp_lim;
      end else if (disp_sh[i] < -disp_lim) begin
        disp_val[i] = -disp_lim;
      end else begin
        disp_val[i] = disp_sh[i];
      end
    end
  end

  // configuration and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_factor      <= 16'd1311;
      smooth_factor       <= 16'd16384;
      smooth_factor_still <= 16'd39322;
      still_level         <= 13'd205;
      peak_margin         <= 12'd41;
      calib_window_ms     <= 16'd800;
      display_limit       <= 14'd8192;
      for (int i = 0; i < 3; i++) begin
        grav[i]    <= '0;
        cal_sum[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        smooth[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        peak[i] <= '0;
      end
      in_cal    <= 1'b1;
      cal_start <= '0;
      cal_count <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRAVITY_FACTOR:      gravity_factor      <= cfg_data[FACTOR_W-1:0];
          REG_SMOOTH_FACTOR:       smooth_factor       <= cfg_data[FACTOR_W-1:0];
          REG_SMOOTH_FACTOR_STILL: smooth_factor_still <= cfg_data[FACTOR_W-1:0];
          REG_STILL_LEVEL:         still_level         <= cfg_data[STILL_W-1:0];
          REG_PEAK_MARGIN:         peak_margin         <= cfg_data[MARGIN_W-1:0];
          REG_CALIB_WINDOW_MS:     calib_window_ms     <= cfg_data[WINDOW_W-1:0];
          REG_DISPLAY_LIMIT:       display_limit       <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_EVENT: begin
          case (op_r)
            OP_RESET_PEAKS: begin
              for (int i = 0; i < 4; i++) peak[i] <= '0;
              for (int i = 0; i < 2; i++) smooth[i] <= '0;
            end
            OP_START_CAL: begin
              for (int i = 0; i < 4; i++) peak[i] <= '0;
              for (int i = 0; i < 2; i++) smooth[i] <= '0;
              for (int i = 0; i < 3; i++) begin
                grav[i]    <= '0;
                cal_sum[i] <= '0;
              end
              in_cal    <= 1'b1;
              cal_start <= time_r;
              cal_count <= '0;
            end
            default: ;
          endcase
        end
        ST_CAL: begin
          // count stops at its maximum and further samples are not summed
          if (cal_count != COUNT_MAX) begin
            for (int i = 0; i < 3; i++) cal_sum[i] <= sum_sat[i];
            cal_count <= cal_count + 1'b1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            grav[ax] <= cal_mean;
            if (ax == LAST_AXIS) begin
              in_cal <= 1'b0;
            end
          end
        end
        ST_TRK_ACC: begin
          grav[ax] <= grav_trk;
        end
        ST_LIN_ACC: begin
          if (ax[0]) begin
            peak[0] <= peak_upd(peak[0], gv, peak_margin);
            peak[1] <= peak_upd(peak[1], gv_neg, peak_margin);
          end else begin
            peak[2] <= peak_upd(peak[2], gv_neg, peak_margin);
            peak[3] <= peak_upd(peak[3], gv, peak_margin);
          end
        end
        ST_SM_ACC: begin
          smooth[ax[0]] <= sm_new;
        end
        default: ;
      endcase
    end
  end

  // transaction latch and lane temporaries
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= s_axis_tuser;
      acc_r[0] <= s_axis_tdata[ACCEL_BITS-1:0];
      acc_r[1] <= s_axis_tdata[2*ACCEL_BITS-1:ACCEL_BITS];
      acc_r[2] <= s_axis_tdata[3*ACCEL_BITS-1:2*ACCEL_BITS];
      time_r   <= s_axis_tdata[3*ACCEL_BITS+TIME_W-1:3*ACCEL_BITS];
    end
    if (state == ST_LIN_ACC) begin
      gq_r <= gq;
      f_r  <= is_still ? smooth_factor_still : smooth_factor;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_cal  <= in_cal;
      out_data <= {{OUT_PAD_W{1'b0}}, peak[3], peak[2], peak[1], peak[0],
                   disp_val[1][DISP_W-1:0], disp_val[0][DISP_W-1:0]};
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_cal;

endmodule

/* hdl/gfgr_mul.sv */
module gfgr_mul import gfgr_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

/* hdl/gfgr_div.sv */
module gfgr_div import gfgr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output div_stat_t          stat,
  output logic [DIV_N_W-1:0] quotient
);

  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_D_W:0] rem_sh;
  logic [DIV_D_W:0] rem_diff;
  logic             fits;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem, quo[DIV_N_W-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    fits     = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

/* hdl/gfgr_checker.sv */
`include "gforce_gravity_removal_peak_tracker_core_macros.svh"

module gfgr_checker import gfgr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  // a stalled result stays offered
  `GFGR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // one item in flight: never ready the cycle after a transaction
  `GFGR_ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // displays read zero while calibrating
  `GFGR_ASSERT_IMPL(a_cal_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[2*DISP_W-1:0] == '0, "display nonzero while calibrating")

  // no result left over from before reset
  `GFGR_ASSERT_IMPL(a_rst_empty, clk, rst, $past(rst), !m_axis_tvalid, "result valid right after reset")

endmodule

bind gforce_gravity_removal_peak_tracker_core gfgr_checker u_gfgr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
